/* sv/rwsa_pkg.sv */
`default_nettype none

package rwsa_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_WARP_X_GAIN  = 3'd0;
    localparam logic [2:0] REG_WARP_Y_GAIN  = 3'd1;
    localparam logic [2:0] REG_RIPPLE_RATE  = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd480;

    // Width of the signed sum of a coordinate and its offset.
    localparam int SUM_W = 12;

    // Quarter wave: entry m holds trunc(sin(m*pi/256) * 32767), m = 0..128.
    localparam int QSIN_ENTRIES = 129;
    localparam real PI_R = 3.14159265358979323846;

    typedef logic [14:0] qsin_tab_t [0:QSIN_ENTRIES-1];

    function automatic qsin_tab_t build_qsin();
        qsin_tab_t t;
        real a;
        for (int m = 0; m < QSIN_ENTRIES; m++)
        begin
            if (m == 0)
            begin
                t[m] = 15'd0;
            end
            else if (m >= 128)
            begin
                t[m] = 15'd32767;
            end
            else
            begin
                a = $sin(real'(m) * PI_R / 256.0) * 32767.0;
                t[m] = 15'(int'($floor(a)));
            end
        end
        return t;
    endfunction

    localparam qsin_tab_t QSIN = build_qsin();

    // Full sine for an even ROM index, given as its half q = (index >> 1) mod 512.
    function automatic logic signed [15:0] sine_lookup(input logic [8:0] q);
        logic [7:0]  idx;
        logic        neg;
        logic [14:0] mag;
        if (q < 9'd128)
        begin
            idx = {1'b0, q[6:0]};
            neg = 1'b0;
        end
        else if (q < 9'd256)
        begin
            idx = 8'(9'd256 - q);
            neg = 1'b0;
        end
        else if (q < 9'd384)
        begin
            idx = {1'b0, q[6:0]};
            neg = 1'b1;
        end
        else
        begin
            idx = 8'(10'd512 - {1'b0, q});
            neg = 1'b1;
        end
        mag = QSIN[idx];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

/* sv/radial_warp_source_address_unit.sv */
// Radial warp source address unit.
// One request per cycle unless the output stalls a full pipeline; six register stages,
// each with its own valid bit, carry each accepted request in order to its result.
// A stage holds only while it and every stage after it are full, so bubbles close up.
// Reset (rst_n low, asynchronous) empties the pipeline, zeroes the gains and the rate,
// and sets the frame to 640 by 480.
`default_nettype none

module radial_warp_source_address_unit #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int SINE_ENTRIES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    // Input stream. tdata, lowest bit up: pixel_x[9:0], pixel_y[19:10],
    // radius_index[28:20], zero padding [31:29].
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    // Output stream. tdata, lowest bit up: source_x[9:0], source_y[19:10],
    // source_address[39:20].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata
);

    // Widths that follow from the largest frame. WW holds the saturated width
    // itself, XW and YW hold a clamped column or row.
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH - 1) : 1;
    localparam int YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT - 1) : 1;
    localparam int AW = YW + WW + 1;
    localparam int STAGES = 6;
    // The phase keeps bits 4 up to the ROM depth; one quarter of the ROM is
    // the cosine shift.
    localparam int QW = $clog2(SINE_ENTRIES) - 1;
    localparam int QUARTER = SINE_ENTRIES / 8;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic signed [7:0] x_gain_reg;
    logic signed [7:0] y_gain_reg;
    logic signed [7:0] rate_reg;
    logic [10:0]       width_reg;
    logic [10:0]       height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg <= '0;
            y_gain_reg <= '0;
            rate_reg   <= '0;
            width_reg  <= rwsa_pkg::FRAME_WIDTH_RESET;
            height_reg <= rwsa_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rwsa_pkg::REG_WARP_X_GAIN:  x_gain_reg <= cfg_data[7:0];
                rwsa_pkg::REG_WARP_Y_GAIN:  y_gain_reg <= cfg_data[7:0];
                rwsa_pkg::REG_RIPPLE_RATE:  rate_reg   <= cfg_data[7:0];
                rwsa_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                rwsa_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame size saturated to 2..MAX, and the clamp limits derived from it.
    logic [WW-1:0] w_sat;
    logic [HW-1:0] h_sat;
    logic [XW-1:0] x_lim;
    logic [YW-1:0] y_lim;

    always_comb
    begin
        if (width_reg < 11'd2)
            w_sat = WW'(2);
        else if (int'(width_reg) > MAX_WIDTH)
            w_sat = WW'(MAX_WIDTH);
        else
            w_sat = WW'(width_reg);

        if (height_reg < 11'd2)
            h_sat = HW'(2);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_sat = HW'(MAX_HEIGHT);
        else
            h_sat = HW'(height_reg);

        x_lim = XW'(w_sat - WW'(2));
        y_lim = YW'(h_sat - HW'(2));
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage k loads when it is empty or when the
    // stage after it moves on; the last stage moves on when the output
    // request is taken.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = s_axis_tvalid;
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (load[k])
                    valid_reg[k] <= valid_next[k];
            end
        end
    end

    assign s_axis_tready = load[0];

    // ------------------------------------------------------------------
    // Stage 1: capture the request.
    // ------------------------------------------------------------------
    logic [9:0] px1_reg, py1_reg;
    logic [8:0] r1_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            px1_reg <= s_axis_tdata[9:0];
            py1_reg <= s_axis_tdata[19:10];
            r1_reg  <= s_axis_tdata[28:20];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: ripple phase c = r * rate. The ROM index is (c >> 3) with the
    // low bit cleared, so only its half c[12:4] is kept.
    // ------------------------------------------------------------------
    logic signed [17:0] phase;
    logic [9:0]         px2_reg, py2_reg;
    logic [QW-1:0]      q2_reg;

    assign phase = 18'($signed({1'b0, r1_reg})) * 18'(rate_reg);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            q2_reg  <= phase[QW+3:4];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sine ROM reads. The horizontal term reads a quarter wave
    // further on, which is the cosine.
    // ------------------------------------------------------------------
    logic [9:0]         px3_reg, py3_reg;
    logic signed [15:0] sin_y3_reg, sin_x3_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
            sin_y3_reg <= rwsa_pkg::sine_lookup(q2_reg);
            sin_x3_reg <= rwsa_pkg::sine_lookup(q2_reg + QW'(QUARTER));
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by the gains.
    // ------------------------------------------------------------------
    logic [9:0]         px4_reg, py4_reg;
    logic signed [23:0] prod_y4_reg, prod_x4_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            px4_reg     <= px3_reg;
            py4_reg     <= py3_reg;
            prod_y4_reg <= 24'(sin_y3_reg) * 24'(y_gain_reg);
            prod_x4_reg <= 24'(sin_x3_reg) * 24'(x_gain_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: offsets are the products shifted down by 15, rounding toward
    // minus infinity (taking the upper bits does exactly that). Add them to
    // the position and clamp into the frame.
    // ------------------------------------------------------------------
    logic signed [8:0]               dx, dy;
    logic signed [rwsa_pkg::SUM_W-1:0] sum_x, sum_y;
    logic [XW-1:0]                   sx_next;
    logic [YW-1:0]                   sy_next;
    logic [XW-1:0]                   sx5_reg;
    logic [YW-1:0]                   sy5_reg;

    always_comb
    begin
        dx    = prod_x4_reg[23:15];
        dy    = prod_y4_reg[23:15];
        sum_x = $signed({2'b00, px4_reg}) + rwsa_pkg::SUM_W'(dx);
        sum_y = $signed({2'b00, py4_reg}) + rwsa_pkg::SUM_W'(dy);

        if (sum_x < 0)
            sx_next = '0;
        else if (int'(sum_x) > int'(x_lim))
            sx_next = x_lim;
        else
            sx_next = XW'(sum_x);

        if (sum_y < 0)
            sy_next = '0;
        else if (int'(sum_y) > int'(y_lim))
            sy_next = y_lim;
        else
            sy_next = YW'(sum_y);
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            sx5_reg <= sx_next;
            sy5_reg <= sy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: linear address, the output register.
    // ------------------------------------------------------------------
    logic [AW-1:0] addr_next;
    logic [AW-1:0] addr6_reg;
    logic [XW-1:0] sx6_reg;
    logic [YW-1:0] sy6_reg;

    assign addr_next = AW'(sy5_reg) * AW'(w_sat) + AW'(sx5_reg);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            sx6_reg   <= sx5_reg;
            sy6_reg   <= sy5_reg;
            addr6_reg <= addr_next;
        end
    end

    // Output fields keep their low bits only.
    logic [31:0] sx_out, sy_out;
    logic [63:0] addr_out;

    assign sx_out   = 32'(sx6_reg);
    assign sy_out   = 32'(sy6_reg);
    assign addr_out = 64'(addr6_reg);

    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = {addr_out[19:0], sy_out[9:0], sx_out[9:0]};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input side stalls only when the whole pipeline is full and the
    // output request is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg) && !m_axis_tready)
    else $error("input stalled while the pipeline had room");

    // An accepted request occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
    else $error("accepted request was lost at the first stage");

    // The fourth stage, when full and unable to move on, keeps its valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !load[4] |=> valid_reg[3])
    else $error("stalled stage dropped its request");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    // The block has a six stage pipeline; this gives it room to settle at the end.
    localparam int DRAIN_CYCLES   = 16;
    // Slowest correct run is far below this: under a thousand requests, each held up at most
    // by a sender gap and a receiver stall.
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 80;
    localparam int MAX_PRINTED    = 100;

    // Expected output of one request, in the order of the output tdata fields.
    typedef struct packed {
        logic [19:0] address;
        logic [9:0]  src_y;
        logic [9:0]  src_x;
    } source_t;

    // Keeps a copy of the register file and of the sine ROM, works out the source
    // position for each accepted input request and checks the output stream in order.
    class warp_scoreboard;
        logic signed [7:0] x_gain;
        logic signed [7:0] y_gain;
        logic signed [7:0] rate;
        logic [10:0]       width_reg;
        logic [10:0]       height_reg;
        int                quarter_wave [0:128];
        source_t           expected_sources [$];
        int                mismatches;

        function new();
            for (int m = 0; m <= 128; m++)
            begin
                quarter_wave[m] = quarter_sine_entry(m);
            end
            x_gain     = 8'sd0;
            y_gain     = 8'sd0;
            rate       = 8'sd0;
            width_reg  = rwsa_pkg::FRAME_WIDTH_RESET;
            height_reg = rwsa_pkg::FRAME_HEIGHT_RESET;
            mismatches = 0;
        endfunction

        // Product of two Q2.62 fractions, kept in Q2.62.
        function longint unsigned mul_q62(longint unsigned a, longint unsigned b);
            longint unsigned a0, a1, b0, b1, ll, lh, hl, hh, mid, lo, hi;
            a0  = a & 64'hFFFF_FFFF;
            a1  = a >> 32;
            b0  = b & 64'hFFFF_FFFF;
            b1  = b >> 32;
            ll  = a0 * b0;
            lh  = a0 * b1;
            hl  = a1 * b0;
            hh  = a1 * b1;
            mid = (ll >> 32) + (lh & 64'hFFFF_FFFF) + (hl & 64'hFFFF_FFFF);
            lo  = (mid << 32) | (ll & 64'hFFFF_FFFF);
            hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
            return (hi << 2) | (lo >> 62);
        endfunction

        // Exact sin(m*pi/256) scaled by 32767 and truncated, from the Taylor series
        // in fixed point, so the table does not depend on the simulator's floats.
        function int quarter_sine_entry(int m);
            longint unsigned pi_q62, x, x2, term, series, a, b, n;
            bit add;
            if (m == 0)
            begin
                return 0;
            end
            if (m >= 128)
            begin
                return 32767;
            end
            pi_q62 = 64'hC90F_DAA2_2168_C235;
            x      = (pi_q62 / 256) * longint'(m) + ((pi_q62 % 256) * longint'(m)) / 256;
            x2     = mul_q62(x, x);
            term   = x;
            series = x;
            n      = 1;
            add    = 1'b0;
            while (term != 0)
            begin
                term   = mul_q62(term, x2) / ((n + 1) * (n + 2));
                n      = n + 2;
                series = add ? series + term : series - term;
                add    = !add;
            end
            a = series >> 31;
            b = series & 64'h7FFF_FFFF;
            return int'((32767 * a + ((32767 * b) >> 31)) >> 31);
        endfunction

        // Full wave from the quarter wave; only even ROM indexes are ever used.
        function int sine_at(int k);
            int q;
            q = (k >> 1) & 511;
            if (q < 128)
            begin
                return quarter_wave[q];
            end
            if (q < 256)
            begin
                return quarter_wave[256 - q];
            end
            if (q < 384)
            begin
                return -quarter_wave[q - 256];
            end
            return -quarter_wave[512 - q];
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_register(logic [2:0] index, logic [10:0] data);
            case (index)
                rwsa_pkg::REG_WARP_X_GAIN:  x_gain     = data[7:0];
                rwsa_pkg::REG_WARP_Y_GAIN:  y_gain     = data[7:0];
                rwsa_pkg::REG_RIPPLE_RATE:  rate       = data[7:0];
                rwsa_pkg::REG_FRAME_WIDTH:  width_reg  = data;
                rwsa_pkg::REG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function source_t predict_source(logic [9:0] px, logic [9:0] py, logic [8:0] radius);
            source_t     s;
            logic [31:0] phase;
            int          rom_idx, w, h, dx, dy, sx, sy;
            w       = clamp(int'(width_reg), 2, 1024);
            h       = clamp(int'(height_reg), 2, 1024);
            phase   = int'(radius) * int'(rate);
            rom_idx = int'(phase[12:3]) & 'h3FE;
            // Arithmetic shifts on signed ints round toward minus infinity.
            dy      = (sine_at(rom_idx) * int'(y_gain)) >>> 15;
            dx      = (sine_at(rom_idx + 256) * int'(x_gain)) >>> 15;
            sx      = clamp(int'(px) + dx, 0, w - 2);
            sy      = clamp(int'(py) + dy, 0, h - 2);
            s.src_x   = sx[9:0];
            s.src_y   = sy[9:0];
            s.address = 20'(sy * w + sx);
            return s;
        endfunction

        function void note_request(logic [31:0] tdata);
            expected_sources.push_back(predict_source(tdata[9:0], tdata[19:10], tdata[28:20]));
        endfunction

        function int pending();
            return expected_sources.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            if (mismatches < MAX_PRINTED)
            begin
                $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            end
            mismatches++;
        endtask

        task check_result(logic [39:0] tdata);
            source_t want;
            source_t got;
            got = tdata;
            if (expected_sources.size() == 0)
            begin
                report_mismatch("result with no request waiting, address", got.address, -1);
                return;
            end
            want = expected_sources.pop_front();
            if (got.src_x !== want.src_x)
            begin
                report_mismatch("source_x", got.src_x, want.src_x);
            end
            if (got.src_y !== want.src_y)
            begin
                report_mismatch("source_y", got.src_y, want.src_y);
            end
            if (got.address !== want.address)
            begin
                report_mismatch("source_address", got.address, want.address);
            end
        endtask
    endclass

    // Clock, reset and every block input start at known values.
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [2:0]  cfg_index     = rwsa_pkg::REG_WARP_X_GAIN;
    logic [10:0] cfg_data      = 11'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = 32'd0;
    logic        m_axis_tready = 1'b0;
    wire logic   cfg_ready;
    wire logic   s_axis_tready;
    wire logic   m_axis_tvalid;
    wire logic [39:0] m_axis_tdata;

    warp_scoreboard sb = new();

    // Sender burst state: in bursty phases a random gap precedes each burst.
    int burst_left = 0;
    bit tx_bursty  = 1'b0;

    int cycle_count = 0;
    int rx_window   = 0;
    int rx_mode     = 0;

    radial_warp_source_address_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit: a hung pipeline or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back pressure. Every window picks a new pattern: always ready,
    // coin flip, mostly stalled, or a square wave from bit 2 of the cycle count.
    always @(posedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_mode   = $urandom_range(0, 3);
            rx_window = $urandom_range(20, 200);
        end
        rx_window--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 5) == 0);
            default: m_axis_tready <= cycle_count[2];
        endcase
    end

    // Observer: every handshake is sampled at the clock edge where it completes.
    // Signals read here still hold their values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_register(cfg_index, cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_request(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata);
            end
        end
    end

    function automatic logic [31:0] pack_request(logic [9:0] px, logic [9:0] py,
                                                 logic [8:0] radius);
        return {3'b000, radius, py, px};
    endfunction

    // Write one register. The valid stays high so that a batch of writes runs
    // back to back; the caller lowers it once the batch is done.
    task automatic set_register(logic [2:0] index, logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Writes all five registers. The upper bits of the 8 bit registers carry
    // random junk, which the block must ignore.
    task automatic configure(logic signed [7:0] xg, logic signed [7:0] yg,
                             logic signed [7:0] rt, logic [10:0] w, logic [10:0] h);
        set_register(rwsa_pkg::REG_WARP_X_GAIN, {3'($urandom), xg});
        set_register(rwsa_pkg::REG_WARP_Y_GAIN, {3'($urandom), yg});
        set_register(rwsa_pkg::REG_RIPPLE_RATE, {3'($urandom), rt});
        set_register(rwsa_pkg::REG_FRAME_WIDTH, w);
        set_register(rwsa_pkg::REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Send one input request. In bursty phases a random gap opens before each
    // burst; otherwise the valid stays high from one request to the next.
    task automatic push_request(logic [31:0] data);
        if (burst_left == 0)
        begin
            if (tx_bursty)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and hold off until every outstanding result has come back.
    // Registers are only written after this. The count is read only once the
    // observer has noted the last accepted request.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [7:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            default: return 8'($urandom);
        endcase
    endfunction

    // Frame sizes lean on the saturation edges: below two, just past the
    // largest frame, and the full 11 bit range.
    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 11'($urandom_range(0, 3));
            1: return 11'($urandom_range(1023, 1025));
            2: return 11'd2047;
            3: return 11'($urandom_range(1026, 2047));
            4: return 11'($urandom_range(2, 16));
            default: return 11'($urandom_range(2, 1024));
        endcase
    endfunction

    // Coordinates fall inside the frame half of the time and anywhere otherwise.
    function automatic logic [9:0] pick_coord(logic [10:0] size);
        int lim;
        lim = (size < 2) ? 2 : ((size > 1024) ? 1024 : int'(size));
        if ($urandom_range(0, 1) == 0)
        begin
            return 10'($urandom);
        end
        return 10'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [8:0] pick_radius();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd511;
            default: return 9'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [7:0] xg, yg, rt;
        logic [10:0]       w, h;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First the reset values: zero gains on a 640 by 480 frame,
        // so positions beyond the frame clamp straight to column 638 and row 478.
        tx_bursty = 1'b0;
        push_request(pack_request(10'd0, 10'd0, 9'd0));
        push_request(pack_request(10'd1023, 10'd1023, 9'd511));
        push_request(pack_request(10'd639, 10'd479, 9'd100));
        push_request(pack_request(10'd5, 10'd700, 9'd3));
        drain();

        // Largest frame with the strongest gains and rate; corners and the four
        // quadrants of the sine wave.
        configure(8'sd127, -8'sd128, 8'sd127, 11'd1024, 11'd1024);
        push_request(pack_request(10'd0, 10'd0, 9'd0));
        push_request(pack_request(10'd1023, 10'd1023, 9'd511));
        push_request(pack_request(10'd0, 10'd1023, 9'd256));
        push_request(pack_request(10'd1023, 10'd0, 9'd8));
        push_request(pack_request(10'd512, 10'd512, 9'd1));
        push_request(pack_request(10'd300, 10'd10, 9'd85));
        push_request(pack_request(10'd10, 10'd300, 9'd170));
        push_request(pack_request(10'd1022, 10'd1022, 9'd511));
        drain();

        // Frame too small: width and height saturate to two, so every source
        // position collapses to the origin. Negative rate walks the wave backward.
        configure(-8'sd128, 8'sd127, -8'sd128, 11'd0, 11'd1);
        push_request(pack_request(10'd0, 10'd0, 9'd511));
        push_request(pack_request(10'd1023, 10'd1023, 9'd255));
        push_request(pack_request(10'd1, 10'd1, 9'd4));
        push_request(pack_request(10'd700, 10'd2, 9'd64));
        drain();

        // Frame too large: both sizes saturate to the largest frame. Gains of plus
        // and minus one give offsets of zero or minus one, rounded down.
        configure(-8'sd1, 8'sd1, -8'sd1, 11'd2047, 11'd1025);
        push_request(pack_request(10'd1023, 10'd1023, 9'd511));
        push_request(pack_request(10'd0, 10'd0, 9'd1));
        push_request(pack_request(10'd1023, 10'd0, 9'd300));
        push_request(pack_request(10'd3, 10'd1022, 9'd77));
        drain();

        // Random part: a fresh register setting per phase, bursty or continuous
        // input, and a full drain between phases.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            xg = pick_gain();
            yg = pick_gain();
            rt = pick_gain();
            w  = pick_size();
            h  = pick_size();
            configure(xg, yg, rt, w, h);
            tx_bursty = (phase % 3) != 0;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                push_request(pack_request(pick_coord(w), pick_coord(h), pick_radius()));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
